// File: src/fhp_pkg.sv
// Package for the frame header parser: op codes, status and kind codes,
// register indexes and the queue entry between the front and back stages.
// No dependencies.
package fhp_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int POS_W        = 4;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_EXPECTED_MAGIC  = 2'd0;
	localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd1;
	localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd1024;

	// Result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_FINAL   = 2'd2;

	// Frame status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_TOO_LONG  = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;

	// Header byte positions
	localparam logic [POS_W-1:0] POS_MAGIC_LO = 4'd0;
	localparam logic [POS_W-1:0] POS_MAGIC_HI = 4'd1;
	localparam logic [POS_W-1:0] POS_VERSION  = 4'd2;
	localparam logic [POS_W-1:0] POS_TYPE     = 4'd3;
	localparam logic [POS_W-1:0] POS_SEQ_0    = 4'd4;
	localparam logic [POS_W-1:0] POS_SEQ_1    = 4'd5;
	localparam logic [POS_W-1:0] POS_SEQ_2    = 4'd6;
	localparam logic [POS_W-1:0] POS_SEQ_3    = 4'd7;
	localparam logic [POS_W-1:0] POS_LEN_LO   = 4'd8;
	localparam logic [POS_W-1:0] POS_LEN_HI   = 4'd9;
	localparam logic [POS_W-1:0] POS_CRC_LO   = 4'd10;
	localparam logic [POS_W-1:0] POS_CRC_HI   = 4'd11;
	localparam logic [POS_W-1:0] POS_LAST     = 4'(HEADER_BYTES - 1);

	// Operations handed from the front to the back
	typedef logic [1:0] op_t;
	localparam op_t OP_HDR_BYTE = 2'd0;
	localparam op_t OP_HDR_DONE = 2'd1;
	localparam op_t OP_PAYLOAD  = 2'd2;
	localparam op_t OP_END      = 2'd3;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
		logic [2:0]       status;
	} entry_t;

endpackage

// File: src/fhp_if.sv
// Stream and configuration interfaces of the frame header parser.
// No dependencies.
interface fhp_rx_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;
	modport source (output valid, command, data_byte, input ready);
	modport sink (input valid, command, data_byte, output ready);
endinterface

interface fhp_tx_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  status;
	logic [15:0] rx_magic;
	logic [7:0]  version;
	logic [7:0]  msg_type;
	logic [31:0] sequence_res;
	logic [15:0] payload_length;
	logic [15:0] frame_crc;
	logic [7:0]  payload_byte;
	logic        last;
	modport source (output valid, kind, status, rx_magic, version, msg_type, sequence_res,
		payload_length, frame_crc, payload_byte, last, input ready);
	modport sink (input valid, kind, status, rx_magic, version, msg_type, sequence_res,
		payload_length, frame_crc, payload_byte, last, output ready);
endinterface

interface fhp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/frame_header_parser.sv
// Frame header parser top level: configuration registers, front stage,
// op queue and back stage. Depends on fhp_pkg, fhp_if and the fhp modules.
// A result passes through the op queue and then the result register before it is offered, when the output is free.
// Throughput: one byte per cycle while the queue is not full; the queue of QUEUE_DEPTH ops absorbs output stalls.
// Reset: arst_n clears frame state, queue and output; magic 0, max length 1024.
module frame_header_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	fhp_rx_if.sink   rx,
	fhp_tx_if.source tx,
	fhp_cfg_if.sink  cfg
);
	import fhp_pkg::*;

	logic [15:0] expected_magic_q;
	logic [15:0] max_payload_len_q;
	logic        push;
	entry_t      push_entry;
	logic        q_full;
	logic        q_valid;
	entry_t      q_entry;
	logic        pop;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_magic_q  <= '0;
			max_payload_len_q <= MAX_PAYLOAD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_EXPECTED_MAGIC) begin
				expected_magic_q <= cfg.data;
			end
			if (cfg.index == REG_MAX_PAYLOAD_LEN) begin
				max_payload_len_q <= cfg.data;
			end
		end
	end

	fhp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx),
		.expected_magic  (expected_magic_q),
		.max_payload_len (max_payload_len_q),
		.q_full          (q_full),
		.push            (push),
		.push_entry      (push_entry)
	);

	fhp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_entry (q_entry)
	);

	fhp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.tx      (tx)
	);

`ifndef SYNTHESIS
	// Front never posts into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("op posted into full queue");

	// Only final status results carry last
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.last |-> tx.kind == KIND_FINAL)
		else $error("last set on non-final result");

	// Payload results carry no status and no last
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.kind == KIND_PAYLOAD |-> tx.status == ST_OK && !tx.last)
		else $error("payload result with status or last");

	// Pop only from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule

// File: src/fhp_front.sv
// Front stage: accepts received bytes, tracks header and payload position,
// checks magic and length, and posts one op per meaningful byte.
// Depends on fhp_pkg and fhp_if.
module fhp_front (
	input  logic            clk,
	input  logic            arst_n,
	fhp_rx_if.sink          rx,
	input  logic [15:0]     expected_magic,
	input  logic [15:0]     max_payload_len,
	input  logic            q_full,
	output logic            push,
	output fhp_pkg::entry_t push_entry
);
	import fhp_pkg::*;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_TRAIL   = 2'd2;

	logic [1:0]       phase_q;
	logic [POS_W-1:0] hdr_cnt_q;
	logic [15:0]      pay_cnt_q;
	logic [15:0]      len_q;
	logic [15:0]      magic_q;
	logic [2:0]       err_q;
	logic             accept;
	logic [2:0]       hdr_status;
	logic [2:0]       end_status;
	logic [16:0]      pay_next;

	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign pay_next = {1'b0, pay_cnt_q} + 17'd1;

	// Classify the header once its last byte is in
	always_comb begin
		if (magic_q != expected_magic) begin
			hdr_status = ST_BAD_MAGIC;
		end else if (len_q > max_payload_len) begin
			hdr_status = ST_TOO_LONG;
		end else begin
			hdr_status = ST_OK;
		end
	end

	// Final status at end of buffer
	always_comb begin
		if (phase_q == PH_HEADER) begin
			end_status = ST_SHORT;
		end else if (err_q == ST_BAD_MAGIC) begin
			end_status = ST_BAD_MAGIC;
		end else if (phase_q == PH_PAYLOAD) begin
			end_status = ST_TRUNC;
		end else begin
			end_status = err_q;
		end
	end

	// Pick the op posted for this byte
	always_comb begin
		push              = 1'b0;
		push_entry.op     = OP_HDR_BYTE;
		push_entry.pos    = hdr_cnt_q;
		push_entry.data   = rx.data_byte;
		push_entry.status = ST_OK;
		if (accept) begin
			if (rx.command) begin
				push              = 1'b1;
				push_entry.op     = OP_END;
				push_entry.status = end_status;
			end else if (phase_q == PH_HEADER) begin
				push = 1'b1;
				if (hdr_cnt_q == POS_LAST) begin
					push_entry.op     = OP_HDR_DONE;
					push_entry.status = hdr_status;
				end
			end else if (phase_q == PH_PAYLOAD) begin
				push          = (err_q == ST_OK);
				push_entry.op = OP_PAYLOAD;
			end
		end
	end

	// Advance frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			pay_cnt_q <= '0;
			len_q     <= '0;
			magic_q   <= '0;
			err_q     <= ST_OK;
		end else if (accept) begin
			if (rx.command) begin
				phase_q   <= PH_HEADER;
				hdr_cnt_q <= '0;
				pay_cnt_q <= '0;
				len_q     <= '0;
				magic_q   <= '0;
				err_q     <= ST_OK;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						hdr_cnt_q <= hdr_cnt_q + 1'b1;
						if (hdr_cnt_q == POS_MAGIC_LO) magic_q[7:0]  <= rx.data_byte;
						if (hdr_cnt_q == POS_MAGIC_HI) magic_q[15:8] <= rx.data_byte;
						if (hdr_cnt_q == POS_LEN_LO)   len_q[7:0]    <= rx.data_byte;
						if (hdr_cnt_q == POS_LEN_HI)   len_q[15:8]   <= rx.data_byte;
						if (hdr_cnt_q == POS_LAST) begin
							err_q <= hdr_status;
							if (hdr_status == ST_BAD_MAGIC || len_q == 16'd0) begin
								phase_q <= PH_TRAIL;
							end else begin
								phase_q <= PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						pay_cnt_q <= pay_next[15:0];
						if (pay_next == {1'b0, len_q}) begin
							phase_q <= PH_TRAIL;
						end
					end
					default: begin
						// Trailing bytes: hold
					end
				endcase
			end
		end
	end

endmodule

// File: src/fhp_queue.sv
// Small register queue decoupling the front and back stages.
// Depends on fhp_pkg.
module fhp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fhp_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output fhp_pkg::entry_t rd_entry
);
	import fhp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/fhp_back.sv
// Back stage: assembles header fields from queued ops and drives the
// result register toward the output channel.
// Depends on fhp_pkg and fhp_if.
module fhp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  fhp_pkg::entry_t q_entry,
	output logic            pop,
	fhp_tx_if.source        tx
);
	import fhp_pkg::*;

	logic [15:0] magic_q, magic_n;
	logic [7:0]  ver_q, ver_n;
	logic [7:0]  type_q, type_n;
	logic [31:0] seq_q, seq_n;
	logic [15:0] len_q, len_n;
	logic [15:0] crc_q, crc_n;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [2:0]  status_q;
	logic [15:0] o_magic_q;
	logic [7:0]  o_ver_q;
	logic [7:0]  o_type_q;
	logic [31:0] o_seq_q;
	logic [15:0] o_len_q;
	logic [15:0] o_crc_q;
	logic [7:0]  o_byte_q;
	logic        o_last_q;
	logic        emits;

	assign emits = (q_entry.op != OP_HDR_BYTE);
	assign pop   = q_valid && (!emits || !out_valid_q || tx.ready);

	// Merge a header byte into the gathered fields
	always_comb begin
		magic_n = magic_q;
		ver_n   = ver_q;
		type_n  = type_q;
		seq_n   = seq_q;
		len_n   = len_q;
		crc_n   = crc_q;
		if (q_entry.op == OP_HDR_BYTE || q_entry.op == OP_HDR_DONE) begin
			unique case (q_entry.pos)
				POS_MAGIC_LO: magic_n[7:0]  = q_entry.data;
				POS_MAGIC_HI: magic_n[15:8] = q_entry.data;
				POS_VERSION:  ver_n         = q_entry.data;
				POS_TYPE:     type_n        = q_entry.data;
				POS_SEQ_0:    seq_n[7:0]    = q_entry.data;
				POS_SEQ_1:    seq_n[15:8]   = q_entry.data;
				POS_SEQ_2:    seq_n[23:16]  = q_entry.data;
				POS_SEQ_3:    seq_n[31:24]  = q_entry.data;
				POS_LEN_LO:   len_n[7:0]    = q_entry.data;
				POS_LEN_HI:   len_n[15:8]   = q_entry.data;
				POS_CRC_LO:   crc_n[7:0]    = q_entry.data;
				POS_CRC_HI:   crc_n[15:8]   = q_entry.data;
				default: begin
				end
			endcase
		end
	end

	// Hold header fields; clear at end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			ver_q   <= '0;
			type_q  <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			crc_q   <= '0;
		end else if (pop) begin
			if (q_entry.op == OP_END) begin
				magic_q <= '0;
				ver_q   <= '0;
				type_q  <= '0;
				seq_q   <= '0;
				len_q   <= '0;
				crc_q   <= '0;
			end else begin
				magic_q <= magic_n;
				ver_q   <= ver_n;
				type_q  <= type_n;
				seq_q   <= seq_n;
				len_q   <= len_n;
				crc_q   <= crc_n;
			end
		end
	end

	// Output valid: set on a result, drop after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (pop && emits) begin
			kind_q    <= KIND_HEADER;
			status_q  <= q_entry.status;
			o_magic_q <= magic_n;
			o_ver_q   <= ver_n;
			o_type_q  <= type_n;
			o_seq_q   <= seq_n;
			o_len_q   <= len_n;
			o_crc_q   <= crc_n;
			o_byte_q  <= '0;
			o_last_q  <= 1'b0;
			unique case (q_entry.op)
				OP_PAYLOAD: begin
					kind_q    <= KIND_PAYLOAD;
					status_q  <= ST_OK;
					o_magic_q <= '0;
					o_ver_q   <= '0;
					o_type_q  <= '0;
					o_seq_q   <= '0;
					o_len_q   <= '0;
					o_crc_q   <= '0;
					o_byte_q  <= q_entry.data;
				end
				OP_END: begin
					kind_q   <= KIND_FINAL;
					o_last_q <= 1'b1;
				end
				default: begin
					// Header result keeps the defaults above
				end
			endcase
		end
	end

	assign tx.valid          = out_valid_q;
	assign tx.kind           = kind_q;
	assign tx.status         = status_q;
	assign tx.rx_magic       = o_magic_q;
	assign tx.version        = o_ver_q;
	assign tx.msg_type       = o_type_q;
	assign tx.sequence_res   = o_seq_q;
	assign tx.payload_length = o_len_q;
	assign tx.frame_crc      = o_crc_q;
	assign tx.payload_byte   = o_byte_q;
	assign tx.last           = o_last_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for frame_header_parser: a queue-fed byte driver, a result
// monitor with its own parser prediction, and a configuration writer between phases.
// Depends on fhp_pkg, the fhp interfaces and the RTL under src.
module tb;
	import fhp_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 320;
	localparam int PHASES         = 6;

	typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_TRAIL} frame_phase_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
	} rx_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [15:0] rx_magic;
		logic [7:0]  version;
		logic [7:0]  msg_type;
		logic [31:0] sequence_res;
		logic [15:0] payload_length;
		logic [15:0] frame_crc;
		logic [7:0]  payload_byte;
		logic        last;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fhp_rx_if  rx_ch();
	fhp_tx_if  tx_ch();
	fhp_cfg_if cfg_ch();

	frame_header_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register copies seen by the predictor
	logic [15:0] cfg_magic = 16'h0000;
	logic [15:0] cfg_max   = MAX_PAYLOAD_RESET;

	// Parser state as predicted
	logic [16:0]  fp_pos     = '0;
	frame_phase_t fp_phase   = PH_HEADER;
	logic [2:0]   fp_err     = ST_OK;
	logic [15:0]  fp_magic   = '0;
	logic [7:0]   fp_version = '0;
	logic [7:0]   fp_type    = '0;
	logic [31:0]  fp_seq     = '0;
	logic [15:0]  fp_len     = '0;
	logic [15:0]  fp_crc     = '0;

	rx_item_t      byte_q[$];
	frame_result_t result_q[$];
	rx_item_t      next_item;

	int items_queued = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int send_gap     = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;
	int mismatches   = 0;

	function automatic frame_result_t gathered_header(input logic [1:0] kind,
			input logic [2:0] status, input logic last);
		frame_result_t r;
		r = '0;
		r.kind           = kind;
		r.status         = status;
		r.rx_magic       = fp_magic;
		r.version        = fp_version;
		r.msg_type       = fp_type;
		r.sequence_res   = fp_seq;
		r.payload_length = fp_len;
		r.frame_crc      = fp_crc;
		r.last           = last;
		return r;
	endfunction

	// Advance the predicted parser by one transfer and queue what it emits
	function automatic void advance_parser(input logic cmd, input logic [7:0] b);
		frame_result_t r;
		logic [2:0] st;
		if (cmd) begin
			if (fp_phase == PH_HEADER)
				st = ST_SHORT;
			else if (fp_err == ST_BAD_MAGIC)
				st = ST_BAD_MAGIC;
			else if (fp_phase == PH_PAYLOAD)
				st = ST_TRUNC;
			else
				st = fp_err;
			result_q.push_back(gathered_header(KIND_FINAL, st, 1'b1));
			fp_pos     = '0;
			fp_phase   = PH_HEADER;
			fp_err     = ST_OK;
			fp_magic   = '0;
			fp_version = '0;
			fp_type    = '0;
			fp_seq     = '0;
			fp_len     = '0;
			fp_crc     = '0;
		end else if (fp_phase == PH_HEADER) begin
			case (fp_pos[POS_W-1:0])
				POS_MAGIC_LO: fp_magic[7:0]   = b;
				POS_MAGIC_HI: fp_magic[15:8]  = b;
				POS_VERSION:  fp_version      = b;
				POS_TYPE:     fp_type         = b;
				POS_SEQ_0:    fp_seq[7:0]     = b;
				POS_SEQ_1:    fp_seq[15:8]    = b;
				POS_SEQ_2:    fp_seq[23:16]   = b;
				POS_SEQ_3:    fp_seq[31:24]   = b;
				POS_LEN_LO:   fp_len[7:0]     = b;
				POS_LEN_HI:   fp_len[15:8]    = b;
				POS_CRC_LO:   fp_crc[7:0]     = b;
				POS_CRC_HI:   fp_crc[15:8]    = b;
				default: ;
			endcase
			fp_pos = fp_pos + 17'd1;
			if (fp_pos >= 17'(HEADER_BYTES)) begin
				// Header complete: judge magic first, then length
				if (fp_magic != cfg_magic) begin
					fp_err   = ST_BAD_MAGIC;
					fp_phase = PH_TRAIL;
				end else begin
					fp_err   = (fp_len > cfg_max) ? ST_TOO_LONG : ST_OK;
					fp_phase = (fp_len == 16'd0) ? PH_TRAIL : PH_PAYLOAD;
				end
				result_q.push_back(gathered_header(KIND_HEADER, fp_err, 1'b0));
			end
		end else if (fp_phase == PH_PAYLOAD) begin
			fp_pos = fp_pos + 17'd1;
			if (fp_pos >= 17'(HEADER_BYTES) + 17'(fp_len))
				fp_phase = PH_TRAIL;
			// Too-long frames count payload but emit nothing
			if (fp_err == ST_OK) begin
				r = '0;
				r.kind         = KIND_PAYLOAD;
				r.payload_byte = b;
				result_q.push_back(r);
			end
		end
	endfunction

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	// Byte driver: predict on each transfer, then offer the next queued byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid     <= 1'b0;
			rx_ch.command   <= 1'b0;
			rx_ch.data_byte <= 8'h00;
			send_gap = 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				advance_parser(rx_ch.command, rx_ch.data_byte);
				items_sent++;
				send_gap = pick_gap(((items_sent / 64) % 4) == 0);
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					rx_ch.valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					next_item = byte_q.pop_front();
					rx_ch.valid     <= 1'b1;
					rx_ch.command   <= next_item.command;
					rx_ch.data_byte <= next_item.data_byte;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		frame_result_t got, want;
		if (!arst_n) begin
			tx_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (tx_ch.valid && tx_ch.ready) begin
				got.kind           = tx_ch.kind;
				got.status         = tx_ch.status;
				got.rx_magic       = tx_ch.rx_magic;
				got.version        = tx_ch.version;
				got.msg_type       = tx_ch.msg_type;
				got.sequence_res   = tx_ch.sequence_res;
				got.payload_length = tx_ch.payload_length;
				got.frame_crc      = tx_ch.frame_crc;
				got.payload_byte   = tx_ch.payload_byte;
				got.last           = tx_ch.last;
				if (result_q.size() == 0) begin
					report("unexpected result, kind", got.kind, 0);
				end else begin
					want = result_q.pop_front();
					if (got.kind !== want.kind)
						report("kind", got.kind, want.kind);
					if (got.status !== want.status)
						report("status", got.status, want.status);
					if (got.rx_magic !== want.rx_magic)
						report("rx_magic", got.rx_magic, want.rx_magic);
					if (got.version !== want.version)
						report("version", got.version, want.version);
					if (got.msg_type !== want.msg_type)
						report("msg_type", got.msg_type, want.msg_type);
					if (got.sequence_res !== want.sequence_res)
						report("sequence_res", got.sequence_res, want.sequence_res);
					if (got.payload_length !== want.payload_length)
						report("payload_length", got.payload_length, want.payload_length);
					if (got.frame_crc !== want.frame_crc)
						report("frame_crc", got.frame_crc, want.frame_crc);
					if (got.payload_byte !== want.payload_byte)
						report("payload_byte", got.payload_byte, want.payload_byte);
					if (got.last !== want.last)
						report("last", got.last, want.last);
				end
				results_seen++;
				stall_left = pick_gap(((results_seen / 48) % 3) == 0);
				// One long hold-off so the block backs up into its input
				if (results_seen == 150)
					stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				tx_ch.ready <= 1'b0;
			end else begin
				tx_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic cmd, input logic [7:0] b);
		rx_item_t it;
		it.command   = cmd;
		it.data_byte = b;
		byte_q.push_back(it);
		items_queued++;
	endtask

	// Queue one frame: the first hdr_bytes header bytes, payload, trailing, end of buffer
	task automatic queue_frame(input logic [15:0] magic, input logic [15:0] len,
			input int hdr_bytes, input int n_pay, input int n_trail);
		logic [7:0] hdr [HEADER_BYTES];
		int i;
		for (i = 0; i < HEADER_BYTES; i++)
			hdr[i] = 8'($urandom);
		hdr[POS_MAGIC_LO] = magic[7:0];
		hdr[POS_MAGIC_HI] = magic[15:8];
		hdr[POS_LEN_LO]   = len[7:0];
		hdr[POS_LEN_HI]   = len[15:8];
		for (i = 0; i < hdr_bytes; i++)
			queue_item(1'b0, hdr[i]);
		if (hdr_bytes == HEADER_BYTES) begin
			for (i = 0; i < n_pay + n_trail; i++)
				queue_item(1'b0, 8'($urandom));
		end
		queue_item(1'b1, 8'($urandom));
	endtask

	// Pick a frame shape: just under half well formed, the rest errored or noise
	task automatic queue_random_frame();
		int r, n, i;
		logic [15:0] len;
		r   = $urandom_range(0, 99);
		len = 16'($urandom_range(0, 16));
		if (r < 45) begin
			queue_frame(cfg_magic, len, HEADER_BYTES, int'(len), $urandom_range(0, 3));
		end else if (r < 60) begin
			// truncated payload
			if ($urandom_range(0, 3) == 0)
				len = 16'($urandom);
			if (len == 16'd0)
				len = 16'd1;
			n = $urandom_range(0, (len > 16'd20) ? 20 : int'(len) - 1);
			queue_frame(cfg_magic, len, HEADER_BYTES, n, 0);
		end else if (r < 72) begin
			// length at or above the limit
			if (cfg_max < 16'd20) begin
				len = cfg_max + 16'($urandom_range(1, 4));
				n   = int'(len);
			end else begin
				len = 16'($urandom_range(int'(cfg_max), 65535));
				n   = $urandom_range(0, 8);
			end
			queue_frame(cfg_magic, len, HEADER_BYTES, n, $urandom_range(0, 2));
		end else if (r < 82) begin
			// bad magic, anything may follow
			if ($urandom_range(0, 1) == 0)
				len = 16'($urandom);
			queue_frame(cfg_magic ^ 16'($urandom_range(1, 65535)), len, HEADER_BYTES,
				$urandom_range(0, 6), $urandom_range(0, 2));
		end else if (r < 90) begin
			queue_frame(16'($urandom), len, $urandom_range(0, HEADER_BYTES - 1), 0, 0);
		end else begin
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				queue_item($urandom_range(0, 3) == 0, 8'($urandom));
			queue_item(1'b1, 8'($urandom));
		end
	endtask

	// Hold until the block has drained, then allow for bytes that emit nothing
	task automatic settle();
		while (byte_q.size() != 0 || rx_ch.valid || result_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == REG_EXPECTED_MAGIC)
			cfg_magic = val;
		else
			cfg_max = val;
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] magic_set [PHASES];
		logic [15:0] max_set [PHASES];
		int p, start;
		magic_set[0] = 16'hA5C3;  max_set[0] = 16'd16;
		magic_set[1] = 16'h0000;  max_set[1] = 16'hFFFF;
		magic_set[2] = 16'($urandom); max_set[2] = 16'd3;
		magic_set[3] = 16'hFFFF;  max_set[3] = 16'($urandom_range(0, 40));
		magic_set[4] = 16'($urandom); max_set[4] = 16'd0;
		magic_set[5] = 16'h5A3C;  max_set[5] = MAX_PAYLOAD_RESET;

		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.command   = 1'b0;
		rx_ch.data_byte = 8'h00;
		tx_ch.ready     = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_EXPECTED_MAGIC;
		cfg_ch.data     = 16'h0000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: end of buffer alone, then a one-byte frame at reset settings
		queue_item(1'b1, 8'hFF);
		queue_frame(16'h0000, 16'd1, HEADER_BYTES, 1, 0);
		settle();

		// Directed: zero length goes straight to trailing bytes
		write_reg(REG_EXPECTED_MAGIC, 16'hFFFF);
		write_reg(REG_MAX_PAYLOAD_LEN, 16'h0000);
		@(negedge clk);
		queue_frame(16'hFFFF, 16'd0, HEADER_BYTES, 0, 1);
		settle();

		// Random phases, one register setting each
		for (p = 0; p < PHASES; p++) begin
			write_reg(REG_EXPECTED_MAGIC, magic_set[p]);
			write_reg(REG_MAX_PAYLOAD_LEN, max_set[p]);
			@(negedge clk);
			start = items_queued;
			while (items_queued - start < PHASE_ITEMS / 2)
				queue_random_frame();
			// sender pause until every result is back
			if (p == 2)
				settle();
			while (items_queued - start < PHASE_ITEMS)
				queue_random_frame();
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
src/fhp_pkg.sv
src/fhp_if.sv
src/fhp_front.sv
src/fhp_queue.sv
src/fhp_back.sv
src/frame_header_parser.sv
bench/tb.sv
